>>> design/nsjf_pkg.sv
// ----------------------------------------------------------------------------
// nsjf_pkg
// Shared widths, state encoding and control structs of the SJF scheduler.
// ----------------------------------------------------------------------------
package nsjf_pkg;

  localparam int MAX_JOBS_DEF = 16;
  localparam int ARR_W        = 16;
  localparam int BURST_W      = 16;
  localparam int JOB_IDX_W    = 4;
  localparam int TIME_W       = 21;
  localparam int SUM_W        = 25;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SCAN,
    ST_DECIDE,
    ST_FINISH,
    ST_TAT,
    ST_WAIT,
    ST_EMIT
  } sched_state_e;

  typedef struct packed {
    logic clr;
    logic vld;
  } scan_ctl_t;

  typedef struct packed {
    logic               found;
    logic               any_wait;
    logic [ARR_W-1:0]   pick_arr;
    logic [BURST_W-1:0] pick_burst;
    logic [ARR_W-1:0]   next_arr;
  } scan_res_t;

endpackage

>>> design/nsjf_ram.sv
// ----------------------------------------------------------------------------
// nsjf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module nsjf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> design/nsjf_scan.sv
// ----------------------------------------------------------------------------
// nsjf_scan
// Selection unit: folds one job entry per cycle into the current best pick
// and the earliest pending arrival.
// ----------------------------------------------------------------------------
module nsjf_scan import nsjf_pkg::*; #(
  parameter int MAX_JOBS = MAX_JOBS_DEF,
  localparam int IDX_W   = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  scan_ctl_t          ctl_i,
  input  logic [IDX_W-1:0]   idx_i,
  input  logic               done_i,
  input  logic [ARR_W-1:0]   arr_i,
  input  logic [BURST_W-1:0] burst_i,
  input  logic [TIME_W-1:0]  time_i,
  output scan_res_t          res_o,
  output logic [IDX_W-1:0]   pick_idx_o
);

  logic               found_q, found_d;
  logic               wait_q, wait_d;
  logic               take_pick, take_wait;
  logic [ARR_W-1:0]   pick_arr_q;
  logic [BURST_W-1:0] pick_burst_q;
  logic [ARR_W-1:0]   next_arr_q;
  logic [IDX_W-1:0]   pick_idx_q;
  logic               arrived;

  always_comb begin
    arrived   = TIME_W'(arr_i) <= time_i;
    take_pick = ctl_i.vld && !done_i && arrived && (!found_q || (burst_i < pick_burst_q));
    take_wait = ctl_i.vld && !done_i && !arrived && (!wait_q || (arr_i < next_arr_q));
    found_d   = ctl_i.clr ? 1'b0 : (found_q || take_pick);
    wait_d    = ctl_i.clr ? 1'b0 : (wait_q || take_wait);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
      wait_q  <= 1'b0;
    end else begin
      found_q <= found_d;
      wait_q  <= wait_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_pick && !ctl_i.clr) begin
      pick_arr_q   <= arr_i;
      pick_burst_q <= burst_i;
      pick_idx_q   <= idx_i;
    end
    if (take_wait && !ctl_i.clr) begin
      next_arr_q <= arr_i;
    end
  end

  assign res_o.found      = found_q;
  assign res_o.any_wait   = wait_q;
  assign res_o.pick_arr   = pick_arr_q;
  assign res_o.pick_burst = pick_burst_q;
  assign res_o.next_arr   = next_arr_q;
  assign pick_idx_o       = pick_idx_q;

endmodule

>>> design/nonpreemptive_sjf_scheduler_unit.sv
// ----------------------------------------------------------------------------
// nonpreemptive_sjf_scheduler_unit
// Non-preemptive shortest-job-first scheduler: loads a job set into RAM,
// then emits one completion record per job in schedule order.
//
//   channel | handshake              | payload
//   --------+------------------------+-------------------------------------
//   in      | in_valid_i/in_ready_o  | arrival_time, burst_time, last_job
//   out     | out_valid_o/out_ready_i| job_index, finish_time, turnaround,
//           |                        | waiting, totals, final_result
//
// Loading takes one request per cycle. Each completion scans the n stored
// jobs with one RAM read per job, then takes the registered read, the decision
// and three add steps. An idle jump to a later arrival adds a full rescan.
// No request is taken while a schedule runs. Reset needs no clearing pass;
// a stalled output holds the schedule in its emit step.
// ----------------------------------------------------------------------------
module nonpreemptive_sjf_scheduler_unit import nsjf_pkg::*; #(
  parameter int MAX_JOBS = MAX_JOBS_DEF,
  localparam int IDX_W   = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1,
  localparam int CNT_W   = $clog2(MAX_JOBS + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [ARR_W-1:0]     arrival_time_i,
  input  logic [BURST_W-1:0]   burst_time_i,
  input  logic                 last_job_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [JOB_IDX_W-1:0] job_index_o,
  output logic [TIME_W-1:0]    finish_time_o,
  output logic [TIME_W-1:0]    turnaround_o,
  output logic [TIME_W-1:0]    waiting_o,
  output logic [SUM_W-1:0]     total_turnaround_o,
  output logic [SUM_W-1:0]     total_waiting_o,
  output logic                 final_result_o
);

  sched_state_e state_q, state_d;

  logic [CNT_W-1:0]    job_count_q;
  logic [CNT_W-1:0]    emitted_q;
  logic [CNT_W-1:0]    issue_q;
  logic                rd_valid_q;
  logic [IDX_W-1:0]    rd_idx_q;
  logic [MAX_JOBS-1:0] done_q;
  logic [TIME_W-1:0]   time_q;
  logic [TIME_W-1:0]   tat_q;
  logic [TIME_W-1:0]   wt_q;
  logic [SUM_W-1:0]    sum_tat_q;
  logic [SUM_W-1:0]    sum_wt_q;
  logic                out_valid_q;

  logic               in_fire;
  logic               load_we;
  logic               scan_clr;
  logic               issue_en;
  logic               scan_last;
  logic               emit_fire;
  logic               out_free;
  logic               is_final;
  scan_ctl_t          scan_ctl;
  scan_res_t          scan_res;
  logic [IDX_W-1:0]   pick_idx;
  logic [ARR_W-1:0]   rd_arr;
  logic [BURST_W-1:0] rd_burst;
  logic [SUM_W-1:0]   sum_tat_d;
  logic [SUM_W-1:0]   sum_wt_d;

  nsjf_ram #(.WIDTH(ARR_W), .DEPTH(MAX_JOBS)) u_arr_ram (
    .clk_i   (clk_i),
    .we_i    (load_we),
    .waddr_i (job_count_q[IDX_W-1:0]),
    .wdata_i (arrival_time_i),
    .raddr_i (issue_q[IDX_W-1:0]),
    .rdata_o (rd_arr)
  );

  nsjf_ram #(.WIDTH(BURST_W), .DEPTH(MAX_JOBS)) u_burst_ram (
    .clk_i   (clk_i),
    .we_i    (load_we),
    .waddr_i (job_count_q[IDX_W-1:0]),
    .wdata_i (burst_time_i),
    .raddr_i (issue_q[IDX_W-1:0]),
    .rdata_o (rd_burst)
  );

  nsjf_scan #(.MAX_JOBS(MAX_JOBS)) u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (scan_ctl),
    .idx_i      (rd_idx_q),
    .done_i     (done_q[rd_idx_q]),
    .arr_i      (rd_arr),
    .burst_i    (rd_burst),
    .time_i     (time_q),
    .res_o      (scan_res),
    .pick_idx_o (pick_idx)
  );

  assign out_free  = !out_valid_q || out_ready_i;
  assign scan_last = rd_valid_q && (CNT_W'(rd_idx_q) == job_count_q - CNT_W'(1));
  assign is_final  = (emitted_q + CNT_W'(1)) == job_count_q;
  assign sum_tat_d = sum_tat_q + SUM_W'(tat_q);
  assign sum_wt_d  = sum_wt_q + SUM_W'(wt_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD:   if (in_valid_i && last_job_i) state_d = ST_SCAN;
      ST_SCAN:   if (scan_last) state_d = ST_DECIDE;
      ST_DECIDE: state_d = scan_res.found ? ST_FINISH : ST_SCAN;
      ST_FINISH: state_d = ST_TAT;
      ST_TAT:    state_d = ST_WAIT;
      ST_WAIT:   state_d = ST_EMIT;
      ST_EMIT:   if (out_free) state_d = is_final ? ST_LOAD : ST_SCAN;
      default:   state_d = ST_LOAD;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    scan_clr   = 1'b0;
    issue_en   = 1'b0;
    emit_fire  = 1'b0;
    unique case (state_q)
      ST_LOAD: begin
        in_ready_o = 1'b1;
        scan_clr   = 1'b1;
      end
      ST_SCAN:   issue_en = issue_q < job_count_q;
      ST_DECIDE: scan_clr = !scan_res.found;
      ST_EMIT: begin
        emit_fire = out_free;
        scan_clr  = out_free;
      end
      default: ;
    endcase
  end

  assign in_fire      = in_valid_i && in_ready_o;
  assign load_we      = in_fire && (job_count_q < CNT_W'(MAX_JOBS));
  assign scan_ctl.clr = scan_clr;
  assign scan_ctl.vld = rd_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      job_count_q <= '0;
      emitted_q   <= '0;
      issue_q     <= '0;
      rd_valid_q  <= 1'b0;
      done_q      <= '0;
      time_q      <= '0;
      sum_tat_q   <= '0;
      sum_wt_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      rd_valid_q <= issue_en;
      if (load_we) begin
        job_count_q <= job_count_q + CNT_W'(1);
      end
      if (scan_clr) begin
        issue_q <= '0;
      end else if (issue_en) begin
        issue_q <= issue_q + CNT_W'(1);
      end
      if (state_q == ST_DECIDE && !scan_res.found) begin
        time_q <= TIME_W'(scan_res.next_arr);
      end else if (state_q == ST_FINISH) begin
        time_q <= time_q + TIME_W'(scan_res.pick_burst);
      end
      if (emit_fire) begin
        out_valid_q <= 1'b1;
        if (is_final) begin
          job_count_q <= '0;
          emitted_q   <= '0;
          done_q      <= '0;
          time_q      <= '0;
          sum_tat_q   <= '0;
          sum_wt_q    <= '0;
        end else begin
          emitted_q        <= emitted_q + CNT_W'(1);
          done_q[pick_idx] <= 1'b1;
          sum_tat_q        <= sum_tat_d;
          sum_wt_q         <= sum_wt_d;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= issue_q[IDX_W-1:0];
    if (state_q == ST_TAT) begin
      tat_q <= time_q - TIME_W'(scan_res.pick_arr);
    end
    if (state_q == ST_WAIT) begin
      wt_q <= tat_q - TIME_W'(scan_res.pick_burst);
    end
    if (emit_fire) begin
      job_index_o        <= JOB_IDX_W'(pick_idx);
      finish_time_o      <= time_q;
      turnaround_o       <= tat_q;
      waiting_o          <= wt_q;
      total_turnaround_o <= sum_tat_d;
      total_waiting_o    <= sum_wt_d;
      final_result_o     <= is_final;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef NO_ASSERTIONS
  a_scan_has_jobs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (job_count_q != '0))
    else $error("scan running with no jobs loaded");

  a_no_double_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_fire |-> !done_q[pick_idx])
    else $error("job completed twice");

  a_load_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (done_q == '0 && emitted_q == '0 && time_q == '0))
    else $error("set state not cleared while loading");

  a_emit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_LOAD) |-> (emitted_q < job_count_q))
    else $error("completion count exceeds job count");
`endif

endmodule
